### sv/i2cmrs_pkg.sv
// Shared types, event codes and packing helpers for the I2C read sequencer.
`timescale 1ns / 1ps

package i2cmrs_pkg;

  // Controller event codes carried in the input tuser.
  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_ACK   = 3'd1,
    OP_NACK  = 3'd2,
    OP_BYTE  = 3'd3,
    OP_STOP  = 3'd4
  } op_t;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int OP_W       = 3;

  // One input word after unpacking.
  typedef struct packed {
    logic [2:0] op;
    logic [6:0] dev_addr;
    logic       read_mode;
    logic [7:0] cmd_code;
    logic [7:0] xfer_length;
    logic [7:0] rx_byte;
  } item_t;

  // One result word.
  typedef struct packed {
    logic       cmd_start;
    logic       cmd_ack;
    logic       cmd_nack;
    logic       cmd_stop;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [7:0] rx_index;
    logic       done_res;
    logic       error;
  } result_t;

  // Build an input item from the stream buses.
  function automatic item_t unpack_item(input logic [OP_W-1:0] user,
                                        input logic [IN_DATA_W-1:0] data);
    item_t it;
    it.op          = user;
    it.dev_addr    = data[6:0];
    it.read_mode   = data[7];
    it.cmd_code    = data[15:8];
    it.xfer_length = data[23:16];
    it.rx_byte     = data[31:24];
    return it;
  endfunction

  // Pack a result, first field in the lowest bit.
  function automatic logic [OUT_DATA_W-1:0] pack_result(input result_t r);
    return {r.error, r.done_res, r.rx_index, r.rx_data, r.rx_valid,
            r.tx_byte, r.tx_valid, r.cmd_stop, r.cmd_nack, r.cmd_ack,
            r.cmd_start};
  endfunction

endpackage

### sv/i2c_master_read_sequencer_core.sv
// Top level of the I2C master command-then-read sequencer.
`timescale 1ns / 1ps

// Usage:
// The input stream carries controller events. in_tuser holds the event code
// (start, ack, nack, byte received, stop done) and in_tdata the start
// parameters and the received byte. Every event word produces exactly one
// result word on the output stream: bus commands (start, ack, nack, stop),
// a byte to transmit, a received byte with its buffer index, a done flag or
// an error flag for an event that is not legal in the current phase.
// The input register captures the word, then the decode logic updates the
// phase and writes the result register, which drives the output stream.
// Throughput is one word per cycle while out_tready stays high. When the
// receiver stalls, the result register holds its word and the input register
// fills; in_tready drops only when both are full and out_tready is low.
// Synchronous reset returns the phase to idle, clears the stored
// transaction values and empties both stages.
module i2c_master_read_sequencer_core
  import i2cmrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Bits from 0: dev_addr[6:0], read_mode, cmd_code[7:0],
  // xfer_length[7:0], rx_byte[7:0].
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Bits from 0: op[2:0].
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Bits from 0: cmd_start, cmd_ack, cmd_nack, cmd_stop, tx_valid,
  // tx_byte[7:0], rx_valid, rx_data[7:0], rx_index[7:0], done_res, error.
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic    item_valid;
  item_t   item;
  logic    item_take;
  result_t res;

  i2cmrs_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  i2cmrs_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (out_tvalid),
    .res        (res),
    .res_ready  (out_tready)
  );

  assign out_tdata = pack_result(res);

  // An error word carries nothing else.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.error) |-> (out_tdata[30:0] == 31'd0))
    else $error("error word has other fields set");

  // A word never both transmits and receives.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(res.tx_valid && res.rx_valid))
    else $error("tx and rx flagged together");

  // Receive fields are zero unless a byte is handed out.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !res.rx_valid) |-> (res.rx_data == 8'd0 && res.rx_index == 8'd0))
    else $error("rx fields set without rx_valid");

  // With the result register empty the input side must be open.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // Reset empties the result register.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

### sv/i2cmrs_in_reg.sv
// Input register stage that holds one unpacked event word.
`timescale 1ns / 1ps

module i2cmrs_in_reg
  import i2cmrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [OP_W-1:0]      in_tuser,
  output logic                 item_valid,
  output item_t                item,
  input  logic                 item_take
);

  logic  valid_r;
  item_t item_r;

  // The stage accepts whenever it is empty or its word moves on this cycle.
  assign in_tready  = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Valid flag and payload capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      item_r <= unpack_item(in_tuser, in_tdata);
    end
  end

endmodule

### sv/i2cmrs_seq.sv
// Transaction phase tracking, event decode and result register.
`timescale 1ns / 1ps

module i2cmrs_seq
  import i2cmrs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_take,
  output logic    res_valid,
  output result_t res,
  input  logic    res_ready
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_CMD   = 3'd2,
    PH_WAIT  = 3'd3,
    PH_READ  = 3'd4,
    PH_CLOSE = 3'd5
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic       rflag_r, rflag_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] want_r, want_nxt;
  logic [7:0] saved_r, saved_nxt;
  logic [7:0] saved_inc;
  logic       valid_r;
  result_t    res_r, res_nxt;
  logic       fire;

  // A word moves in when the result register is free or being drained.
  assign item_take = !valid_r || res_ready;
  assign fire      = item_valid && item_take;
  assign res_valid = valid_r;
  assign res       = res_r;
  assign saved_inc = saved_r + 8'd1;

  // Event decode against the current phase.
  always_comb begin
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    rflag_nxt = rflag_r;
    cmd_nxt   = cmd_r;
    want_nxt  = want_r;
    saved_nxt = saved_r;
    res_nxt   = '0;
    case (op_t'(item.op))
      OP_START: begin
        if (phase_r == PH_IDLE) begin
          addr_nxt          = item.dev_addr;
          rflag_nxt         = item.read_mode;
          cmd_nxt           = item.cmd_code;
          want_nxt          = item.xfer_length;
          saved_nxt         = 8'd0;
          phase_nxt         = PH_ADDR;
          res_nxt.cmd_start = 1'b1;
          res_nxt.tx_valid  = 1'b1;
          res_nxt.tx_byte   = {item.dev_addr, 1'b0};
        end else begin
          res_nxt.error = 1'b1;
        end
      end
      OP_ACK: begin
        if (phase_r == PH_ADDR) begin
          phase_nxt        = PH_CMD;
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_byte  = cmd_r;
        end else if (phase_r == PH_CMD) begin
          // Without a read, the ack after the command is ignored.
          if (rflag_r) begin
            phase_nxt         = PH_WAIT;
            res_nxt.cmd_start = 1'b1;
            res_nxt.tx_valid  = 1'b1;
            res_nxt.tx_byte   = {addr_r, 1'b1};
          end
        end else if (phase_r == PH_WAIT) begin
          phase_nxt = PH_READ;
        end else begin
          res_nxt.error = 1'b1;
        end
      end
      OP_NACK: begin
        // Device still converting: repeat the read address.
        if (phase_r == PH_WAIT) begin
          if (rflag_r) begin
            res_nxt.cmd_start = 1'b1;
            res_nxt.tx_valid  = 1'b1;
            res_nxt.tx_byte   = {addr_r, 1'b1};
          end
        end else begin
          res_nxt.error = 1'b1;
        end
      end
      OP_BYTE: begin
        if (phase_r == PH_READ) begin
          res_nxt.rx_valid = 1'b1;
          res_nxt.rx_data  = item.rx_byte;
          res_nxt.rx_index = saved_r;
          saved_nxt        = saved_inc;
          if (saved_inc >= want_r) begin
            phase_nxt        = PH_CLOSE;
            res_nxt.cmd_nack = 1'b1;
            res_nxt.cmd_stop = 1'b1;
          end else begin
            res_nxt.cmd_ack = 1'b1;
          end
        end else begin
          res_nxt.error = 1'b1;
        end
      end
      OP_STOP: begin
        if (phase_r == PH_CLOSE) begin
          phase_nxt        = PH_IDLE;
          res_nxt.done_res = 1'b1;
        end else begin
          res_nxt.error = 1'b1;
        end
      end
      default: begin
        res_nxt.error = 1'b1;
      end
    endcase
  end

  // State, result valid and result payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      addr_r  <= '0;
      rflag_r <= 1'b0;
      cmd_r   <= '0;
      want_r  <= '0;
      saved_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        addr_r  <= addr_nxt;
        rflag_r <= rflag_nxt;
        cmd_r   <= cmd_nxt;
        want_r  <= want_nxt;
        saved_r <= saved_nxt;
      end
      if (item_take) begin
        valid_r <= item_valid;
      end
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

endmodule
